FILE: rtl/crt_pkg.sv
// shared types and constants of the command retry tracker
package crt_pkg;

    // recorded state of a command slot
    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_RUNNING   = 3'd1,
        ST_SUCCEEDED = 3'd2,
        ST_FAILED    = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_EXPIRED   = 3'd5
    } rec_state_t;

    // command codes, code 3 is unused and acts as a query
    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_QUERY    = 2'd2
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd0;
    localparam logic [1:0] CFG_INIT_BACKOFF = 2'd1;
    localparam logic [1:0] CFG_MAX_BACKOFF  = 2'd2;

    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd3;
    localparam logic [31:0] INIT_BACKOFF_RST = 32'd100;
    localparam logic [31:0] MAX_BACKOFF_RST  = 32'd30000;

    localparam int SLOT_W   = 6;
    localparam int SLOT_IDS = 1 << SLOT_W;
    localparam logic [7:0] CNT_MAX = 8'hFF;

    // one entry of the slot table
    typedef struct packed {
        rec_state_t  state;
        logic [7:0]  cnt;
        logic [63:0] expiry;
    } entry_t;

endpackage

FILE: rtl/command_retry_tracker_top.sv
// command retry tracker: slot table with read-modify-write and capped doubling backoff
// done follows the start transfer through the stage 1, stage 2 and result registers
// a new command is taken only once the previous one is through the table read-modify-write
//   (synchronous read of the entry, then update and write-back)
// reset: after rst_n is released busy stays high while a clearing
//   pass zeroes the table one entry a cycle; configuration writes are taken throughout
// the receiver cannot stall: each result is shown for exactly one cycle
module command_retry_tracker_top
    import crt_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          op,
    input  logic [SLOT_W-1:0]   slot,
    input  logic [63:0]         now_ms,
    input  logic [63:0]         expires_at_ms,
    input  logic                success,
    // result channel
    output logic                done,
    output logic [2:0]          record_state,
    output logic [7:0]          attempt_count,
    output logic                retry_allowed,
    output logic [31:0]         backoff_ms,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // slot id to table index, wrapping modulo SLOTS (constant table)
    logic [AW-1:0] slot_map [SLOT_IDS];
    for (genvar g = 0; g < SLOT_IDS; g++) begin : g_slot_map
        assign slot_map[g] = AW'(g % SLOTS);
    end

    // the slot table
    entry_t mem [SLOTS];
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    entry_t          rd_q;

    // configuration registers
    logic [7:0]  max_attempts_reg;
    logic [31:0] init_backoff_reg;
    logic [31:0] max_backoff_reg;

    // clearing pass after reset
    logic            clearing_reg;
    logic [AW-1:0]   clr_idx_reg;

    // stage 1: command held while the table read completes
    logic            s1_valid_reg;
    op_t             s1_op_reg;
    logic [AW-1:0]   s1_idx_reg;
    logic [63:0]     s1_now_reg;
    logic [63:0]     s1_expires_reg;
    logic            s1_success_reg;
    logic            s1_expired_reg;

    // stage 2: updated entry, backoff still to be worked out
    logic            s2_valid_reg;
    rec_state_t      s2_state_reg;
    logic [7:0]      s2_cnt_reg;
    logic            s2_retry_reg;
    logic [7:0]      s2_shift_reg;

    // registered result
    logic            done_reg;
    rec_state_t      record_state_reg;
    logic [7:0]      attempt_count_reg;
    logic            retry_allowed_reg;
    logic [31:0]     backoff_ms_reg;

    logic            accept;
    logic            begin_expired;

    // stage 1 results
    entry_t          upd_entry;
    logic            upd_write;
    logic            upd_retry;
    logic [7:0]      upd_shift;
    logic            upd_exp_hit;

    // stage 2 results
    logic [63:0]     bo_wide;
    logic [31:0]     backoff_next;

    // only one command is in the read-modify-write at a time, so a command accepted
    // as soon as busy falls reads the entry the previous one has just written
    assign busy      = clearing_reg | s1_valid_reg;
    assign accept    = start & ~busy;
    assign cfg_ready = 1'b1;

    // expiry of a begin command, checked on the way in
    assign begin_expired = (expires_at_ms != 64'd0) && (expires_at_ms <= now_ms);

    // update of the entry read from the table
    always_comb
    begin
        upd_entry = rd_q;
        upd_write = 1'b0;
        case (s1_op_reg)
            OP_BEGIN:
            begin
                upd_write = 1'b1;
                if (rd_q.state == ST_SUCCEEDED || rd_q.state == ST_RUNNING) begin
                    upd_entry.state = ST_DUPLICATE;
                end else if (s1_expired_reg) begin
                    // stored expiry left as it was
                    upd_entry.state = ST_EXPIRED;
                    upd_entry.cnt   = 8'd0;
                end else begin
                    upd_entry.state  = ST_RUNNING;
                    upd_entry.expiry = s1_expires_reg;
                    if (rd_q.state == ST_NONE) begin
                        upd_entry.cnt = 8'd1;
                    end else if (rd_q.cnt != CNT_MAX) begin
                        upd_entry.cnt = rd_q.cnt + 8'd1;
                    end
                end
            end
            OP_COMPLETE:
            begin
                upd_write       = 1'b1;
                upd_entry.state = s1_success_reg ? ST_SUCCEEDED : ST_FAILED;
                if (rd_q.state == ST_NONE) begin
                    upd_entry.cnt = 8'd0;
                end
            end
            default:
            begin
                // query, and the unused code: report only
                if (rd_q.state == ST_NONE) begin
                    upd_entry.cnt = 8'd0;
                end
            end
        endcase
    end

    // retry decision and doubling count on the updated entry
    always_comb
    begin
        upd_exp_hit = (upd_entry.expiry != 64'd0) && (upd_entry.expiry <= s1_now_reg);
        upd_retry   = (upd_entry.state == ST_FAILED) && !upd_exp_hit &&
                      (upd_entry.cnt < max_attempts_reg);
        if (upd_entry.state == ST_NONE || upd_entry.cnt == 8'd0) begin
            upd_shift = 8'd0;
        end else begin
            upd_shift = upd_entry.cnt - 8'd1;
        end
    end

    // capped doubling: min(initial * 2^k, cap) for k >= 1, initial for k = 0
    always_comb
    begin
        bo_wide = {32'd0, init_backoff_reg} << s2_shift_reg[4:0];
        if (s2_shift_reg == 8'd0) begin
            backoff_next = init_backoff_reg;
        end else if (init_backoff_reg == 32'd0) begin
            backoff_next = 32'd0;
        end else if (s2_shift_reg[7:5] != 3'd0) begin
            backoff_next = max_backoff_reg;
        end else if (bo_wide < {32'd0, max_backoff_reg}) begin
            backoff_next = bo_wide[31:0];
        end else begin
            backoff_next = max_backoff_reg;
        end
    end

    // table write port: clearing pass or write-back of stage 1
    always_comb
    begin
        if (clearing_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_valid_reg & upd_write;
            mem_waddr = s1_idx_reg;
            mem_wdata = upd_entry;
        end
    end

    // slot table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_q <= mem[slot_map[slot]];
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clearing_reg     <= 1'b1;
            clr_idx_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            done_reg         <= 1'b0;
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            init_backoff_reg <= INIT_BACKOFF_RST;
            max_backoff_reg  <= MAX_BACKOFF_RST;
        end else begin
            if (clearing_reg) begin
                if (clr_idx_reg == AW'(SLOTS - 1)) begin
                    clearing_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MAX_ATTEMPTS: max_attempts_reg <= cfg_data[7:0];
                    CFG_INIT_BACKOFF: init_backoff_reg <= cfg_data;
                    CFG_MAX_BACKOFF:  max_backoff_reg  <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // payload registers of the stages
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_op_reg      <= op_t'(op);
            s1_idx_reg     <= slot_map[slot];
            s1_now_reg     <= now_ms;
            s1_expires_reg <= expires_at_ms;
            s1_success_reg <= success;
            s1_expired_reg <= begin_expired;
        end
        if (s1_valid_reg) begin
            s2_state_reg <= upd_entry.state;
            s2_cnt_reg   <= upd_entry.cnt;
            s2_retry_reg <= upd_retry;
            s2_shift_reg <= upd_shift;
        end
        if (s2_valid_reg) begin
            record_state_reg  <= s2_state_reg;
            attempt_count_reg <= s2_cnt_reg;
            retry_allowed_reg <= s2_retry_reg;
            backoff_ms_reg    <= backoff_next;
        end
    end

    assign done          = done_reg;
    assign record_state  = record_state_reg;
    assign attempt_count = attempt_count_reg;
    assign retry_allowed = retry_allowed_reg;
    assign backoff_ms    = backoff_ms_reg;

endmodule

FILE: rtl/crt_checker.sv
// port-level checks of the command retry tracker and their binding
module crt_checker
    import crt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [2:0]  record_state,
    input  logic [7:0]  attempt_count,
    input  logic        retry_allowed
);

    // a transfer in gives its result once it has passed stage 1, stage 2 and the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after command transfer");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after command transfer");

    a_no_back_to_back_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe on two cycles in a row");

    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && record_state == ST_NONE) |-> (attempt_count == 8'd0 && !retry_allowed))
        else $error("empty slot reported with attempts or retry");

    a_retry_only_failed: assert property (@(posedge clk) disable iff (!rst_n)
        (done && retry_allowed) |-> (record_state == ST_FAILED))
        else $error("retry allowed on a slot that has not failed");

endmodule

bind command_retry_tracker_top crt_checker u_crt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .record_state  (record_state),
    .attempt_count (attempt_count),
    .retry_allowed (retry_allowed)
);

FILE: tb/tb_top.sv
// testbench for the command retry tracker: directed and random commands checked against a slot table model
`timescale 1ns / 1ps

module tb_top;
    import crt_pkg::*;

    // unused command code, the block treats it as a query
    localparam logic [1:0]  OP_SPARE    = 2'd3;
    localparam logic [63:0] TIME_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
    // cycles with no transfer of any kind before the run is abandoned
    localparam int          STALL_LIMIT = 1000;
    // mismatch lines printed before going quiet
    localparam int          PRINT_LIMIT = 40;

    // one command as driven on the command channel
    typedef struct {
        logic [1:0]  code;
        logic [5:0]  id;
        logic [63:0] now;
        logic [63:0] exp;
        logic        ok;
    } command_t;

    // one result as the block should show it
    typedef struct {
        rec_state_t  state;
        logic [7:0]  tries;
        logic        retry;
        logic [31:0] backoff;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [5:0]  slot;
    logic [63:0] now_ms;
    logic [63:0] expires_at_ms;
    logic        success;
    logic        done;
    logic [2:0]  record_state;
    logic [7:0]  attempt_count;
    logic        retry_allowed;
    logic [31:0] backoff_ms;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    // model copy of the slot table and the registers
    rec_state_t  slot_state  [SLOT_IDS];
    logic [7:0]  slot_tries  [SLOT_IDS];
    logic [63:0] slot_expiry [SLOT_IDS];
    logic [7:0]  cap_tries;
    logic [31:0] first_wait;
    logic [31:0] wait_cap;

    // results owed by the block, oldest first
    outcome_t    outcomes_due [$];

    int          error_count  = 0;
    int          stall_cycles = 0;
    bit          gaps_on      = 1'b1;
    logic [63:0] wall_ms      = 64'd1000;

    command_retry_tracker_top #(
        .SLOTS(SLOT_IDS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .slot         (slot),
        .now_ms       (now_ms),
        .expires_at_ms(expires_at_ms),
        .success      (success),
        .done         (done),
        .record_state (record_state),
        .attempt_count(attempt_count),
        .retry_allowed(retry_allowed),
        .backoff_ms   (backoff_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // print one mismatch line (up to a limit) and count it
    task automatic note_error(input string what);
        if (error_count < PRINT_LIMIT)
            $display("tb_top: mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // apply one command to the model table and work out the result it owes
    function automatic outcome_t retry_outcome(input command_t c);
        outcome_t    o;
        rec_state_t  prev;
        logic [63:0] wait_ms;
        logic [63:0] doubled;
        int unsigned steps;
        prev = slot_state[c.id];
        case (c.code)
            OP_BEGIN:
            begin
                // running or finished commands are not run twice
                if (prev == ST_SUCCEEDED || prev == ST_RUNNING)
                begin
                    o.state = ST_DUPLICATE;
                    o.tries = slot_tries[c.id];
                end
                // expiry already passed: count drops to zero, stored expiry kept
                else if (c.exp != 64'd0 && c.exp <= c.now)
                begin
                    o.state = ST_EXPIRED;
                    o.tries = 8'd0;
                end
                else
                begin
                    slot_expiry[c.id] = c.exp;
                    o.state = ST_RUNNING;
                    if (prev == ST_NONE)
                        o.tries = 8'd1;
                    else if (slot_tries[c.id] == CNT_MAX)
                        o.tries = CNT_MAX;
                    else
                        o.tries = slot_tries[c.id] + 8'd1;
                end
                slot_state[c.id] = o.state;
                slot_tries[c.id] = o.tries;
            end
            OP_COMPLETE:
            begin
                o.state = c.ok ? ST_SUCCEEDED : ST_FAILED;
                o.tries = (prev == ST_NONE) ? 8'd0 : slot_tries[c.id];
                slot_state[c.id] = o.state;
                slot_tries[c.id] = o.tries;
            end
            default:
            begin
                // query and the spare code leave the table alone
                o.state = prev;
                o.tries = (prev == ST_NONE) ? 8'd0 : slot_tries[c.id];
            end
        endcase
        // retry decision and backoff come from the slot after the update
        o.retry = slot_state[c.id] == ST_FAILED
                  && (slot_expiry[c.id] == 64'd0 || slot_expiry[c.id] > c.now)
                  && slot_tries[c.id] < cap_tries;
        wait_ms = {32'd0, first_wait};
        if (slot_state[c.id] != ST_NONE)
            for (steps = 1; steps < slot_tries[c.id]; steps++)
            begin
                doubled = wait_ms << 1;
                wait_ms = (doubled < {32'd0, wait_cap}) ? doubled : {32'd0, wait_cap};
            end
        o.backoff = wait_ms[31:0];
        return o;
    endfunction

    function automatic command_t cmd_of(input logic [1:0] code, input logic [5:0] id,
                                        input logic [63:0] now, input logic [63:0] exp,
                                        input logic ok);
        command_t c;
        c.code = code;
        c.id   = id;
        c.now  = now;
        c.exp  = exp;
        c.ok   = ok;
        return c;
    endfunction

    // never, later, already passed (sometimes exactly now) or anything at all
    function automatic logic [63:0] pick_expiry(input logic [63:0] now);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return 64'd0;
        else if (pick < 60)
            return now + 64'($urandom_range(1, 200));
        else if (pick < 80)
            return now - 64'($urandom_range(0, 200));
        else
            return {$urandom, $urandom};
    endfunction

    // hand one command over; start is left high so back-to-back commands need no gap
    task automatic send_cmd(input command_t c);
        outcome_t owed;
        if (gaps_on && $urandom_range(0, 99) < 7)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start         <= 1'b1;
        op            <= c.code;
        slot          <= c.id;
        now_ms        <= c.now;
        expires_at_ms <= c.exp;
        success       <= c.ok;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // transfer at this edge
        owed         = retry_outcome(c);
        outcomes_due = {outcomes_due, owed};
    endtask

    // hold commands off until every owed result has come back
    task automatic wait_results();
        start <= 1'b0;
        @(posedge clk);
        while (outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    // write all three registers once the block has gone quiet
    task automatic set_config(input logic [7:0] tries_max, input logic [31:0] init_wait,
                              input logic [31:0] max_wait);
        logic [31:0] value;
        wait_results();
        for (int r = 0; r < 3; r++)
        begin
            value = (r == CFG_MAX_ATTEMPTS) ? {24'd0, tries_max} :
                    (r == CFG_INIT_BACKOFF) ? init_wait : max_wait;
            cfg_valid <= 1'b1;
            cfg_index <= r[1:0];
            cfg_data  <= value;
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
            case (r[1:0])
                CFG_MAX_ATTEMPTS: cap_tries  = value[7:0];
                CFG_INIT_BACKOFF: first_wait = value;
                default:          wait_cap   = value;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic command_t random_command();
        command_t    c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        c.code = (pick < 40) ? OP_BEGIN : (pick < 75) ? OP_COMPLETE :
                 (pick < 95) ? OP_QUERY : OP_SPARE;
        // a few busy slots so that sequences build up, the rest anywhere
        c.id = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 7)) :
                                              6'($urandom_range(0, 63));
        if ($urandom_range(0, 9) == 0)
            c.now = {$urandom, $urandom};
        else
        begin
            wall_ms += 64'($urandom_range(0, 50));
            c.now = wall_ms;
        end
        c.exp = pick_expiry(c.now);
        c.ok  = ($urandom_range(0, 9) < 3);
        return c;
    endfunction

    // begin, sometimes a query, then complete, mostly failing, on one slot
    task automatic run_retry_chains(input int unsigned chains);
        logic [5:0] id;
        repeat (chains)
        begin
            id = 6'($urandom_range(0, 63));
            repeat ($urandom_range(1, 10))
            begin
                wall_ms += 64'($urandom_range(1, 40));
                send_cmd(cmd_of(OP_BEGIN, id, wall_ms, pick_expiry(wall_ms),
                                1'($urandom_range(0, 1))));
                if ($urandom_range(0, 9) < 3)
                    send_cmd(cmd_of(OP_QUERY, id, wall_ms + 64'($urandom_range(0, 20)),
                                    64'd0, 1'($urandom_range(0, 1))));
                wall_ms += 64'($urandom_range(1, 40));
                send_cmd(cmd_of(OP_COMPLETE, id, wall_ms, {$urandom, $urandom},
                                ($urandom_range(0, 9) < 2)));
            end
        end
    endtask

    // hand-picked cases under the reset register values
    task automatic test_directed();
        // no record yet: query and completes on empty slots
        send_cmd(cmd_of(OP_QUERY,    6'd0, 64'd0, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_COMPLETE, 6'd1, 64'd10, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_COMPLETE, 6'd5, 64'd10, 64'd0, 1'b1));
        // begin, duplicate, begin after a duplicate, failure
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1000, 64'd0, 1'b1));
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1001, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1002, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_COMPLETE, 6'd2, 64'd1003, 64'd0, 1'b0));
        // expiry equal to now counts as passed
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1100, 64'd1100, 1'b0));
        send_cmd(cmd_of(OP_QUERY,    6'd2, 64'd1100, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1100, 64'd1101, 1'b0));
        send_cmd(cmd_of(OP_COMPLETE, 6'd2, 64'd1101, 64'd0, 1'b1));
        send_cmd(cmd_of(OP_BEGIN,    6'd2, 64'd1102, 64'd0, 1'b0));
        // expired begin on a fresh slot
        send_cmd(cmd_of(OP_BEGIN,    6'd3, 64'd500, 64'd499, 1'b0));
        // far end of the time range, top slot
        send_cmd(cmd_of(OP_BEGIN,    6'd63, TIME_MAX, TIME_MAX, 1'b1));
        send_cmd(cmd_of(OP_BEGIN,    6'd63, TIME_MAX, 64'd0, 1'b1));
        send_cmd(cmd_of(OP_COMPLETE, 6'd63, TIME_MAX, TIME_MAX, 1'b0));
        send_cmd(cmd_of(OP_SPARE,    6'd63, TIME_MAX, 64'd0, 1'b1));
        // retry allowed until now reaches the stored expiry
        send_cmd(cmd_of(OP_BEGIN,    6'd4, 64'd0, TIME_MAX, 1'b0));
        send_cmd(cmd_of(OP_COMPLETE, 6'd4, 64'd5, 64'd0, 1'b0));
        send_cmd(cmd_of(OP_QUERY,    6'd4, TIME_MAX, 64'd0, 1'b0));
        // begin after a failure that had no record
        send_cmd(cmd_of(OP_BEGIN,    6'd1, 64'd20, 64'd0, 1'b0));
    endtask

    // one register setting, then retry sequences and random commands under it
    task automatic sweep_step(input logic [7:0] tries_max, input logic [31:0] init_wait,
                              input logic [31:0] max_wait);
        set_config(tries_max, init_wait, max_wait);
        run_retry_chains(6);
        repeat (40)
            send_cmd(random_command());
    endtask

    // register extremes, initial backoff above the cap, then back to reset values
    task automatic test_config_sweep();
        sweep_step(8'd0,   32'd0,          32'd0);
        sweep_step(8'd255, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
        sweep_step(8'd1,   32'd5000,       32'd300);
        sweep_step(8'd10,  32'd1,          32'hFFFF_FFFF);
        sweep_step(8'd4,   32'd7,          32'd1000);
        sweep_step(MAX_ATTEMPTS_RST, INIT_BACKOFF_RST, MAX_BACKOFF_RST);
    endtask

    // drive one slot past 255 attempts, back to back with no gaps
    task automatic test_attempt_saturation();
        set_config(8'd255, 32'd1, 32'hFFFF_FFFF);
        gaps_on = 1'b0;
        repeat (260)
        begin
            wall_ms += 64'd1;
            send_cmd(cmd_of(OP_BEGIN, 6'd40, wall_ms, 64'd0, 1'b0));
            send_cmd(cmd_of(OP_COMPLETE, 6'd40, wall_ms, 64'd0, 1'b0));
        end
        send_cmd(cmd_of(OP_QUERY, 6'd40, wall_ms, 64'd0, 1'b0));
        gaps_on = 1'b1;
    endtask

    // random registers per phase; phase 2 runs with no gaps, phase 1 pauses midway
    task automatic test_random_mix();
        for (int phase = 0; phase < 4; phase++)
        begin
            set_config(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                                     8'($urandom_range(0, 6)),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 2000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60000));
            gaps_on = (phase != 2);
            run_retry_chains(8);
            for (int n = 0; n < 200; n++)
            begin
                if (phase == 1 && n == 100)
                    wait_results();
                send_cmd(random_command());
            end
        end
        gaps_on = 1'b1;
    endtask

    // each strobed result against the oldest owed one
    always @(posedge clk)
    begin : check_results
        outcome_t due;
        if (done === 1'b1)
        begin
            if (outcomes_due.size() == 0)
                note_error("result strobe with no result owed");
            else
            begin
                due = outcomes_due.pop_front();
                if (record_state !== due.state)
                    note_error($sformatf("record_state %0d, want %0d",
                                         record_state, due.state));
                if (attempt_count !== due.tries)
                    note_error($sformatf("attempt_count %0d, want %0d",
                                         attempt_count, due.tries));
                if (retry_allowed !== due.retry)
                    note_error($sformatf("retry_allowed %0b, want %0b",
                                         retry_allowed, due.retry));
                if (backoff_ms !== due.backoff)
                    note_error($sformatf("backoff_ms %0d, want %0d",
                                         backoff_ms, due.backoff));
            end
        end
    end

    // watchdog: any command, result or register transfer restarts the count
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        op            <= OP_QUERY;
        slot          <= '0;
        now_ms        <= '0;
        expires_at_ms <= '0;
        success       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MAX_ATTEMPTS;
        cfg_data      <= '0;
        // model starts from the reset table and register values
        foreach (slot_state[k])
        begin
            slot_state[k]  = ST_NONE;
            slot_tries[k]  = 8'd0;
            slot_expiry[k] = 64'd0;
        end
        cap_tries  = MAX_ATTEMPTS_RST;
        first_wait = INIT_BACKOFF_RST;
        wait_cap   = MAX_BACKOFF_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // the clearing pass after reset shows up as busy, send_cmd just waits it out
        test_directed();
        test_config_sweep();
        test_attempt_saturation();
        test_random_mix();
        wait_results();
        // keep the clock running to catch any stray strobe
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
